@@ sv/b36_pkg.sv @@
// ----------------------------------------------------------------------------
// b36_pkg
// Shared types, constants and the digit character function for the base-36
// digit encoder.
// ----------------------------------------------------------------------------
package b36_pkg;

  // default depth of the digit store
  localparam int unsigned DEF_MAX_DIGITS = 13;

  // input value and division chunking
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned NUM_CHUNK = VALUE_W / CHUNK_W;
  localparam int unsigned CHUNK_CW  = $clog2(NUM_CHUNK);

  // digit and character widths
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  // one partial dividend: remainder in front of one chunk
  localparam int unsigned PART_W  = DIGIT_W + CHUNK_W;
  // dividend / 36 is done as (dividend >> 2) / 9 by reciprocal multiply
  localparam int unsigned QUART_W = PART_W - 2;
  localparam int unsigned RECIP_S = QUART_W + 3;
  localparam int unsigned RECIP_W = QUART_W;
  localparam logic [RECIP_W-1:0] Recip9 = RECIP_W'(((1 << RECIP_S) + 8) / 9);
  localparam int unsigned PROD_W  = QUART_W + RECIP_W;

  localparam logic [DIGIT_W-1:0] Radix = DIGIT_W'(36);

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic digit_done;
    logic conv_done;
    logic emit_last;
  } stat_t;

  // remainder to lowercase ascii digit
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_W'(10)) begin
      ch = CHAR_W'(48) + CHAR_W'(d);
    end else if (d < Radix) begin
      ch = CHAR_W'(87) + CHAR_W'(d);
    end else begin
      ch = CHAR_W'(48);
    end
    return ch;
  endfunction

endpackage

@@ sv/b36_ctrl.sv @@
// ----------------------------------------------------------------------------
// b36_ctrl
// Sequencer for the base-36 encoder: load, divide digit by digit, then
// emit the stored digits.
// ----------------------------------------------------------------------------
module b36_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  b36_pkg::stat_t stat,
  output b36_pkg::cmd_t  cmd,
  output logic          busy
);
  import b36_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.digit_done && stat.conv_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/b36_dpath.sv @@
// ----------------------------------------------------------------------------
// b36_dpath
// Datapath for the base-36 encoder: chunked divide-by-36 unit, digit store
// and registered character output.
// ----------------------------------------------------------------------------
module b36_dpath #(
  parameter int unsigned MAX_DIGITS = b36_pkg::DEF_MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  b36_pkg::cmd_t                 cmd,
  input  logic [b36_pkg::VALUE_W-1:0]   value,
  output b36_pkg::stat_t                stat,
  output logic                          strobe,
  output logic [b36_pkg::CHAR_W-1:0]    char_code,
  output logic                          last_char
);
  import b36_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

  logic [VALUE_W-1:0]  quot;
  logic [DIGIT_W-1:0]  rem;
  logic [CHUNK_CW-1:0] chunk;
  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic [DIGIT_W-1:0]  store [MAX_DIGITS];

  logic [PART_W-1:0]   part;
  logic [QUART_W-1:0]  quart;
  logic [PROD_W-1:0]   prod;
  logic [CHUNK_W-1:0]  qchunk;
  logic [PART_W-1:0]   qtimes;
  logic [PART_W-1:0]   rem_wide;
  logic [DIGIT_W-1:0]  rem_new;
  logic [VALUE_W-1:0]  quot_next;
  logic                last_chunk;

  // one chunk of long division by 36: top chunk behind the running remainder
  always_comb begin
    part      = {rem, quot[VALUE_W-1 -: CHUNK_W]};
    quart     = part[PART_W-1:2];
    prod      = PROD_W'(quart) * PROD_W'(Recip9);
    qchunk    = prod[RECIP_S +: CHUNK_W];
    qtimes    = (PART_W'(qchunk) << 5) + (PART_W'(qchunk) << 2);
    rem_wide  = part - qtimes;
    rem_new   = rem_wide[DIGIT_W-1:0];
    quot_next = {quot[VALUE_W-CHUNK_W-1:0], qchunk};
  end

  assign last_chunk = (chunk == CHUNK_CW'(NUM_CHUNK - 1));

  // status to the controller
  always_comb begin
    stat.digit_done = last_chunk;
    stat.conv_done  = (quot_next == '0) || (wr_idx == IDX_W'(MAX_DIGITS - 1));
    stat.emit_last  = (rd_idx == '0);
  end

  // quotient, remainder and index registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot   <= value;
      rem    <= '0;
      chunk  <= '0;
      wr_idx <= '0;
    end else if (cmd.step) begin
      quot  <= quot_next;
      chunk <= chunk + CHUNK_CW'(1);
      if (last_chunk) begin
        rem    <= '0;
        wr_idx <= wr_idx + IDX_W'(1);
        rd_idx <= wr_idx;
      end else begin
        rem <= rem_new;
      end
    end else if (cmd.emit) begin
      rd_idx <= rd_idx - IDX_W'(1);
    end
  end

  // digit store write
  always_ff @(posedge clk) begin
    if (cmd.step && last_chunk) begin
      store[wr_idx] <= rem_new;
    end
  end

  // registered character output
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_code <= digit_char(store[rd_idx]);
      last_char <= (rd_idx == '0);
    end
  end

  // output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

@@ sv/base36_digit_encoder.sv @@
// ----------------------------------------------------------------------------
// base36_digit_encoder
// Converts an unsigned 64-bit value into lowercase base-36 ascii text,
// most significant character first.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. Its n characters
// (1 to 13, no leading zeros, zero gives "0") come out one per cycle on
// char_code, each marked by strobe for exactly one cycle, with last_char on
// the final one; the receiver cannot stall them. Division runs through a
// 16-bit-chunk divide-by-36 unit, one chunk at a time for each digit; busy
// stays high while dividing and emitting, the last character shows in the
// cycle busy falls, and no new value is taken until then.
module base36_digit_encoder #(
  parameter int unsigned MAX_DIGITS = b36_pkg::DEF_MAX_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [b36_pkg::VALUE_W-1:0] value,
  output logic                        strobe,
  output logic [b36_pkg::CHAR_W-1:0]  char_code,
  output logic                        last_char
);
  import b36_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  b36_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // divider, digit store and output register
  b36_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .stat      (stat),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

  // the final character ends the item's output
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_char |=> !strobe)
    else $error("character strobe after last character");

  // characters before the last one come while busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |-> busy)
    else $error("non-final character while idle");

  // an accepted item starts dividing with no character pending
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !strobe)
    else $error("accepted item did not start cleanly");

  // commands from the sequencer never overlap
  a_cmd_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.emit}))
    else $error("overlapping datapath commands");

endmodule

@@ tb/sv/base36_digit_encoder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base36_digit_encoder_test
// Self-checking bench for the base-36 digit encoder. A directed table covers
// zero, single digits, radix boundaries and the widest values. Random values
// of every bit length follow, with idle gaps of varying length on the
// command side. Every strobed character is checked against the table text
// or, where there is none, a local repeated-division model of the conversion.
// ----------------------------------------------------------------------------
module base36_digit_encoder_test;
  import b36_pkg::*;

  localparam int unsigned NumDigitsMax = 13;
  localparam int unsigned NumDirected  = 20;
  localparam int unsigned RandItems    = 310;

  // one expected character of the text
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // directed row: empty text means the model works it out
  typedef struct {
    logic [VALUE_W-1:0] val;
    string              text;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] value;
  logic               strobe;
  logic [CHAR_W-1:0]  char_code;
  logic               last_char;

  text_char_t  expected_chars[$];
  text_char_t  want;
  int unsigned mismatch_count = 0;

  dir_row_t dir_rows [NumDirected] = '{
    '{64'd0, "0"},
    '{64'd1, "1"},
    '{64'd9, "9"},
    '{64'd10, "a"},
    '{64'd35, "z"},
    '{64'd36, "10"},
    '{64'd71, "1z"},
    '{64'd1295, "zz"},
    '{64'd1296, "100"},
    '{64'd2176782335, "zzzzzz"},
    '{64'd4738381338321616895, ""},
    '{64'd4738381338321616896, "1000000000000"},
    '{64'hFFFF_FFFF_FFFF_FFFF, "3w5e11264sgsf"},
    '{64'hFFFF_FFFF_FFFF_FFFE, ""},
    '{64'h8000_0000_0000_0000, ""},
    '{64'h5555_5555_5555_5555, ""},
    '{64'hAAAA_AAAA_AAAA_AAAA, ""},
    '{64'h0000_0000_FFFF_FFFF, ""},
    '{64'hFFFF_FFFF_0000_0000, ""},
    '{64'h0123_4567_89AB_CDEF, ""}
  };

  base36_digit_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // divide by 36 until the quotient is zero, then queue the digits msd first
  function automatic void encode_base36(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] q;
    logic [DIGIT_W-1:0] rems [NumDigitsMax];
    int unsigned        n;
    string              digits;
    text_char_t         c;
    digits = "0123456789abcdefghijklmnopqrstuvwxyz";
    q = v;
    n = 0;
    do begin
      rems[n] = DIGIT_W'(q % 64'd36);
      q = q / 64'd36;
      n++;
    end while (n < NumDigitsMax && q != 0);
    for (int k = int'(n) - 1; k >= 0; k--) begin
      c.code = CHAR_W'(digits[rems[k]]);
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // optional idle gap, then hold the item until the block takes it
  task automatic send_value(input logic [VALUE_W-1:0] v, input string text,
                            input int unsigned idle_pct);
    int unsigned gap;
    text_char_t  c;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 70);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    value = v;
    do @(posedge clk); while (busy);
    if (text.len() == 0) begin
      encode_base36(v);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        c.code = CHAR_W'(text[i]);
        c.last = (i == text.len() - 1);
        expected_chars.push_back(c);
      end
    end
    @(negedge clk);
  endtask

  // check each strobed character against the oldest expected one
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, got char_code %0d last_char %0b",
                 $time, char_code, last_char);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.code) begin
          $display("%0t: char_code mismatch: expected %0d, got %0d",
                   $time, want.code, char_code);
          mismatch_count++;
        end
        if (last_char !== want.last) begin
          $display("%0t: last_char mismatch: expected %0b, got %0b",
                   $time, want.last, last_char);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned        idle_pct;
    int unsigned        w;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    rst   = 1'b1;
    start = 1'b0;
    value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (dir_rows[i]) send_value(dir_rows[i].val, dir_rows[i].text, 20);

    // random values: light idling, heavy idling, then back to back
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 20 : (ph == 1) ? 55 : 0;
      repeat (RandItems / 3) begin
        if ($urandom_range(7) == 0) begin
          // near a power of 36, where the digit count steps
          p = 64'd1;
          repeat ($urandom_range(1, 12)) p = p * 64'd36;
          v = p + 64'($urandom_range(2)) - 64'd1;
        end else begin
          // random bit length spreads the digit counts
          w = $urandom_range(64);
          v = {$urandom, $urandom};
          if (w < 64) v = v & ((64'd1 << w) - 64'd1);
        end
        send_value(v, "", idle_pct);
      end
    end
    start = 1'b0;

    // drain, then allow for any stray characters
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[base36_digit_encoder] OK");
    end else begin
      $display("[base36_digit_encoder] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("[base36_digit_encoder] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
sv/b36_pkg.sv
sv/b36_ctrl.sv
sv/b36_dpath.sv
sv/base36_digit_encoder.sv
tb/sv/base36_digit_encoder_test.sv
